// ===== hw/rtl/dobd_pkg.sv =====
// Shared types, constants and a calendar function for the date offset block.
package dobd_pkg;

  // Width of the signed day offset that is taken from the input.
  localparam int OFFSET_BITS = 16;
  // Day accumulator: offset plus a day of month, signed, one guard bit.
  localparam int DAY_W = OFFSET_BITS + 1;
  localparam int YEAR_W = 14;

  localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1900);
  localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0] LEAP_CYCLE = YEAR_W'(400);
  localparam logic [YEAR_W-1:0] LEAP_CYCLE_LAST = YEAR_W'(399);
  localparam logic [YEAR_W-1:0] CENTURY_1 = YEAR_W'(100);
  localparam logic [YEAR_W-1:0] CENTURY_2 = YEAR_W'(200);
  localparam logic [YEAR_W-1:0] CENTURY_3 = YEAR_W'(300);

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAYS_DEC = 5'd31;
  localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic [4:0] MONTH_LEN [13] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic reduce;
    logic mark_bad;
    logic add_off;
    logic fwd;
    logic bwd;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_bad;
    logic r400_big;
    logic date_bad;
    logic halted;
    logic fwd_more;
    logic bwd_more;
  } sts_t;

  // Days in a month; months outside 1..12 read as zero length.
  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    begin
      n = (month > MONTH_DEC) ? 5'd0 : MONTH_LEN[month];
      if (month == MONTH_FEB && leap) begin
        n = DAYS_FEB_LEAP;
      end
      return n;
    end
  endfunction

endpackage

// ===== hw/rtl/dobd_ctrl.sv =====
// Controller state machine that sequences the date offset datapath.
module dobd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  input  dobd_pkg::sts_t sts,
  output dobd_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_MOVE,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = 1'b0;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        priority if (sts.year_bad) begin
          cmd.mark_bad = 1'b1;
          state_nxt = S_FINISH;
        end else if (sts.r400_big) begin
          cmd.reduce = 1'b1;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.date_bad) begin
          cmd.mark_bad = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          cmd.add_off = 1'b1;
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        priority if (sts.halted) begin
          state_nxt = S_FINISH;
        end else if (sts.fwd_more) begin
          cmd.fwd = 1'b1;
        end else if (sts.bwd_more) begin
          cmd.bwd = 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/dobd_dp.sv =====
// Datapath of the date offset block: date registers, leap tracking and month stepping.
module dobd_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dobd_pkg::cmd_t                     cmd,
  output dobd_pkg::sts_t                     sts,
  input  logic [dobd_pkg::YEAR_W-1:0]        in_start_year,
  input  logic [3:0]                         in_start_month,
  input  logic [4:0]                         in_start_day,
  input  logic signed [dobd_pkg::OFFSET_BITS-1:0] in_day_offset,
  output logic [dobd_pkg::YEAR_W-1:0]        out_result_year,
  output logic [3:0]                         out_result_month,
  output logic [4:0]                         out_result_day,
  output logic [1:0]                         out_status
);

  localparam int DW = dobd_pkg::DAY_W;
  localparam int YW = dobd_pkg::YEAR_W;

  logic [YW-1:0]                        year_r;
  logic [3:0]                           month_r;
  logic signed [DW-1:0]                 day_r;
  logic [dobd_pkg::OFFSET_BITS-1:0]     off_r;
  logic [YW-1:0]                        r400_r;
  logic                                 year_bad_r;
  logic [1:0]                           st_r;
  logic [YW-1:0]                        res_year_r;
  logic [3:0]                           res_month_r;
  logic [4:0]                           res_day_r;
  logic [1:0]                           res_status_r;

  logic                 leap;
  logic [4:0]           dim_cur;
  logic [4:0]           dim_prev;
  logic [3:0]           month_prev;
  logic signed [DW-1:0] dim_cur_x;
  logic signed [DW-1:0] dim_prev_x;
  logic signed [DW-1:0] off_x;

  // r400_r holds the year modulo 400 once reduced; century years that are
  // not a multiple of 400 are not leap years.
  assign leap = (year_r[1:0] == 2'b00) && (r400_r != dobd_pkg::CENTURY_1) &&
                (r400_r != dobd_pkg::CENTURY_2) && (r400_r != dobd_pkg::CENTURY_3);

  assign dim_cur    = dobd_pkg::days_in_month(month_r, leap);
  assign month_prev = (month_r == dobd_pkg::MONTH_JAN) ? dobd_pkg::MONTH_DEC : month_r - 4'd1;
  assign dim_prev   = dobd_pkg::days_in_month(month_prev, leap);
  assign dim_cur_x  = $signed({{(DW-5){1'b0}}, dim_cur});
  assign dim_prev_x = $signed({{(DW-5){1'b0}}, dim_prev});
  assign off_x      = $signed({off_r[dobd_pkg::OFFSET_BITS-1], off_r});

  always_comb begin
    sts.year_bad = year_bad_r;
    sts.r400_big = (r400_r >= dobd_pkg::LEAP_CYCLE);
    sts.date_bad = (month_r == 4'd0) || (month_r > dobd_pkg::MONTH_DEC) ||
                   (day_r == '0) || (day_r > dim_cur_x);
    sts.halted   = (st_r != dobd_pkg::STATUS_OK);
    sts.fwd_more = (day_r > dim_cur_x);
    sts.bwd_more = (day_r < $signed(DW'(1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dobd_pkg::STATUS_OK;
      year_bad_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        year_r <= in_start_year;
        month_r <= in_start_month;
        day_r <= $signed({{(DW-5){1'b0}}, in_start_day});
        off_r <= in_day_offset;
        r400_r <= in_start_year;
        year_bad_r <= (in_start_year < dobd_pkg::YEAR_MIN) ||
                      (in_start_year > dobd_pkg::YEAR_MAX);
        st_r <= dobd_pkg::STATUS_OK;
      end
      if (cmd.reduce) begin
        r400_r <= r400_r - dobd_pkg::LEAP_CYCLE;
      end
      if (cmd.mark_bad) begin
        st_r <= dobd_pkg::STATUS_BAD_DATE;
      end
      if (cmd.add_off) begin
        day_r <= day_r + off_x;
      end
      if (cmd.fwd) begin
        day_r <= day_r - dim_cur_x;
        if (month_r == dobd_pkg::MONTH_DEC) begin
          month_r <= dobd_pkg::MONTH_JAN;
          year_r <= year_r + YW'(1);
          r400_r <= (r400_r == dobd_pkg::LEAP_CYCLE_LAST) ? '0 : r400_r + YW'(1);
          if (year_r == dobd_pkg::YEAR_MAX) begin
            st_r <= dobd_pkg::STATUS_RANGE;
          end
        end else begin
          month_r <= month_r + 4'd1;
        end
      end
      if (cmd.bwd) begin
        month_r <= month_prev;
        if (month_r == dobd_pkg::MONTH_JAN) begin
          // December never depends on the leap rule.
          day_r <= day_r + $signed({{(DW-5){1'b0}}, dobd_pkg::DAYS_DEC});
          year_r <= year_r - YW'(1);
          r400_r <= (r400_r == '0) ? dobd_pkg::LEAP_CYCLE_LAST : r400_r - YW'(1);
          if (year_r == dobd_pkg::YEAR_MIN) begin
            st_r <= dobd_pkg::STATUS_RANGE;
          end
        end else begin
          day_r <= day_r + dim_prev_x;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status_r <= st_r;
      if (st_r == dobd_pkg::STATUS_OK) begin
        res_year_r <= year_r;
        res_month_r <= month_r;
        res_day_r <= day_r[4:0];
      end else begin
        res_year_r <= '0;
        res_month_r <= '0;
        res_day_r <= '0;
      end
    end
  end

  assign out_result_year  = res_year_r;
  assign out_result_month = res_month_r;
  assign out_result_day   = res_day_r;
  assign out_status       = res_status_r;

endmodule

// ===== hw/rtl/date_offset_by_days.sv =====
// Top level of the date offset block: moves a Gregorian date by a signed day count.
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------------------
//  input     start & !busy        in_start_year, in_start_month, in_start_day,
//                                 in_day_offset
//  result    out_valid (1 cycle)  out_result_year, out_result_month, out_result_day,
//                                 out_status
//
// One transaction is worked on at a time; busy stays high from the accepting edge
// until the result strobe. A transaction runs through the load, the 400-year
// reductions of the start year (at most 24), the date check and the month stepper,
// which moves the date one month per cycle. An out-of-range start year finishes
// before the reductions; an invalid start date finishes after the check.
// Reset is synchronous and active low; it returns the controller to idle and drops
// the strobe. The receiver cannot stall: out_valid is high for exactly one cycle and
// the result registers hold their value until the next transaction finishes.
module date_offset_by_days (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [dobd_pkg::YEAR_W-1:0]             in_start_year,
  input  logic [3:0]                              in_start_month,
  input  logic [4:0]                              in_start_day,
  input  logic signed [dobd_pkg::OFFSET_BITS-1:0] in_day_offset,
  output logic                                    out_valid,
  output logic [dobd_pkg::YEAR_W-1:0]             out_result_year,
  output logic [3:0]                              out_result_month,
  output logic [4:0]                              out_result_day,
  output logic [1:0]                              out_status
);

  dobd_pkg::cmd_t cmd;
  dobd_pkg::sts_t sts;

  // The controller walks through load, leap-cycle reduction, date check and
  // month stepping; it never looks at the date itself, only at status flags.
  dobd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath keeps the date, the year modulo 400 for the leap rule, and
  // the day count that is worked down one month length per step.
  dobd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_day_offset    (in_day_offset),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_status       (out_status)
  );

endmodule

// ===== dv/date_offset_checker.sv =====
// Checker for the date offset block: predicts each result and compares it field by field.
`timescale 1ns / 100ps

module date_offset_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic                                    busy,
  input  logic [dobd_pkg::YEAR_W-1:0]             in_start_year,
  input  logic [3:0]                              in_start_month,
  input  logic [4:0]                              in_start_day,
  input  logic signed [dobd_pkg::OFFSET_BITS-1:0] in_day_offset,
  input  logic                                    out_valid,
  input  logic [dobd_pkg::YEAR_W-1:0]             out_result_year,
  input  logic [3:0]                              out_result_month,
  input  logic [4:0]                              out_result_day,
  input  logic [1:0]                              out_status,
  output int                                      fail_count,
  output int                                      pending,
  output int                                      n_checked,
  output int                                      n_bad_date,
  output int                                      n_range
);

  localparam int YW = dobd_pkg::YEAR_W;
  localparam int OW = dobd_pkg::OFFSET_BITS;

  typedef struct {
    logic [YW-1:0] year;
    logic [3:0]    month;
    logic [4:0]    day;
    logic [1:0]    status;
  } moved_date_t;

  moved_date_t expected_dates[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    n_checked  = 0;
    n_bad_date = 0;
    n_range    = 0;
  end

  function automatic bit is_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(input int y, input int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12:      return 31;
      4, 6, 9, 11:                return 30;
      int'(dobd_pkg::MONTH_FEB):  return is_leap(y) ? 29 : 28;
      default:                    return 0;
    endcase
  endfunction

  // Walks the date one month at a time, the same way the block's stepper does.
  function automatic moved_date_t move_date(input logic [YW-1:0] y, input logic [3:0] m,
                                            input logic [4:0] d,
                                            input logic signed [OW-1:0] off);
    moved_date_t r;
    int year;
    int month;
    int day;
    logic [1:0] st;
    year  = int'(y);
    month = int'(m);
    day   = int'(d);
    st    = dobd_pkg::STATUS_OK;
    if (year < int'(dobd_pkg::YEAR_MIN) || year > int'(dobd_pkg::YEAR_MAX) ||
        month < 1 || month > 12 || day < 1 || day > month_days(year, month)) begin
      st = dobd_pkg::STATUS_BAD_DATE;
    end else begin
      day += int'(off);
      while (st == dobd_pkg::STATUS_OK && day > month_days(year, month)) begin
        day -= month_days(year, month);
        month++;
        if (month == 13) begin
          month = 1;
          year++;
          if (year > int'(dobd_pkg::YEAR_MAX)) st = dobd_pkg::STATUS_RANGE;
        end
      end
      while (st == dobd_pkg::STATUS_OK && day < 1) begin
        month--;
        if (month == 0) begin
          month = 12;
          year--;
          if (year < int'(dobd_pkg::YEAR_MIN)) st = dobd_pkg::STATUS_RANGE;
        end
        day += month_days(year, month);
      end
    end
    if (st != dobd_pkg::STATUS_OK) begin
      year  = 0;
      month = 0;
      day   = 0;
    end
    r.year   = YW'(year);
    r.month  = 4'(month);
    r.day    = 5'(day);
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  // The result is compared before the new transaction is queued, since a strobe at the
  // same edge as an acceptance belongs to the earlier transaction.
  always @(posedge clk) begin
    moved_date_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("result %0d-%0d-%0d status %0d with nothing expected",
                                    out_result_year, out_result_month, out_result_day,
                                    out_status));
        end else begin
          want = expected_dates.pop_front();
          n_checked++;
          if (want.status == dobd_pkg::STATUS_BAD_DATE) n_bad_date++;
          if (want.status == dobd_pkg::STATUS_RANGE) n_range++;
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d, expected %0d", out_status,
                                      want.status));
          if (out_result_year !== want.year)
            report_mismatch($sformatf("year got %0d, expected %0d", out_result_year,
                                      want.year));
          if (out_result_month !== want.month)
            report_mismatch($sformatf("month got %0d, expected %0d", out_result_month,
                                      want.month));
          if (out_result_day !== want.day)
            report_mismatch($sformatf("day got %0d, expected %0d", out_result_day,
                                      want.day));
        end
      end
      if (start && !busy) begin
        expected_dates.push_back(move_date(in_start_year, in_start_month, in_start_day,
                                           in_day_offset));
      end
      pending = expected_dates.size();
    end
  end

endmodule

// ===== dv/tb_date_offset_by_days.sv =====
// Testbench top for the date offset block: drives stimulus and gives the verdict.
`timescale 1ns / 100ps

module tb_date_offset_by_days;

  localparam int YW = dobd_pkg::YEAR_W;
  localparam int OW = dobd_pkg::OFFSET_BITS;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [YW-1:0]        in_start_year;
  logic [3:0]           in_start_month;
  logic [4:0]           in_start_day;
  logic signed [OW-1:0] in_day_offset;
  logic                 out_valid;
  logic [YW-1:0]        out_result_year;
  logic [3:0]           out_result_month;
  logic [4:0]           out_result_day;
  logic [1:0]           out_status;

  int fail_count;
  int pending;
  int n_checked;
  int n_bad_date;
  int n_range;
  int n_sent;

  date_offset_by_days u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_day_offset    (in_day_offset),
    .out_valid        (out_valid),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_status       (out_status)
  );

  // The checker sits beside the block, watches both channels and keeps the expected
  // results. The top only reads its counters back.
  date_offset_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_day_offset    (in_day_offset),
    .out_valid        (out_valid),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .pending          (pending),
    .n_checked        (n_checked),
    .n_bad_date       (n_bad_date),
    .n_range          (n_range)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The slowest correct run is about 540 transactions that each step the whole offset range
  // month by month, plus the longest idle gaps, near 5 ms. This limit allows several times that.
  initial begin
    #40_000_000;
    $display("Timeout with %0d results still outstanding.", pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one transaction at the falling edge and holds it until the block takes it.
  // Start is left high on purpose: the caller lowers it only when a gap follows, so a
  // back-to-back transaction never sees start dropped and raised in the same step.
  task automatic send_date(input int y, input int m, input int d, input int off);
    @(negedge clk);
    in_start_year  <= YW'(y);
    in_start_month <= 4'(m);
    in_start_day   <= 5'(d);
    in_day_offset  <= OW'(off);
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  // Most gaps are zero or short; a few are long. A gap of zero keeps start high.
  task automatic idle_gap();
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (r < 55) g = 0;
    else if (r < 90) g = $urandom_range(1, 4);
    else g = $urandom_range(10, 60);
    if (g > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat ($urandom_range(1, 8)) @(negedge clk);
  endtask

  initial begin
    int r;
    int y;
    int m;
    int d;
    int off;
    n_sent         = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_start_year  = '0;
    in_start_month = '0;
    in_start_day   = '0;
    in_day_offset  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed transactions, sent back to back: the year range limits, the leap-year
    // rules for February, every way a start date can be invalid, and offset extremes.
    send_date(1900, 1, 1, 0);
    send_date(1900, 1, 1, -1);          // Steps below the first year.
    send_date(9999, 12, 31, 0);
    send_date(9999, 12, 31, 1);         // Steps past the last year.
    send_date(1900, 1, 1, 32767);       // Largest positive offset.
    send_date(9999, 12, 31, -32768);    // Most negative offset.
    send_date(2000, 2, 29, 0);          // Divisible by 400, so a leap year.
    send_date(1900, 2, 29, 0);          // Divisible by 100 only, so not a leap year.
    send_date(2100, 2, 29, 5);
    send_date(2024, 2, 29, 365);
    send_date(2023, 2, 29, 1);
    send_date(2000, 2, 28, 1);
    send_date(1999, 12, 31, 1);         // Carry into the next year.
    send_date(2000, 1, 1, -1);          // Borrow from the previous year.
    send_date(1901, 1, 1, -365);        // Lands exactly on the first day of the range.
    send_date(1901, 1, 1, -366);
    send_date(1899, 12, 31, 0);         // Year just below the range.
    send_date(10000, 1, 1, 0);          // Year just above the range.
    send_date(16383, 15, 31, -1);       // Every input bit set.
    send_date(2020, 0, 10, 3);          // Month zero.
    send_date(2020, 13, 10, 3);         // Month past December.
    send_date(2020, 5, 0, 3);           // Day zero.
    send_date(2020, 4, 31, 3);          // Day past the end of a 30-day month.
    send_date(2020, 1, 31, 30);
    drain_results();

    // Random part. Most transactions carry well-formed dates so that the month stepper
    // runs in both directions; some sit near the range limits, some use short offsets
    // around month ends, and the rest is unconstrained noise on every field.
    for (int i = 0; i < 516; i++) begin
      r   = $urandom_range(0, 99);
      off = int'($urandom_range(0, 65535)) - 32768;
      m   = $urandom_range(1, 12);
      d   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 28) : $urandom_range(29, 31);
      if (r < 60) begin
        y = $urandom_range(1900, 9999);
      end else if (r < 75) begin
        y = $urandom_range(0, 1) ? $urandom_range(1900, 1990) : $urandom_range(9909, 9999);
      end else if (r < 88) begin
        y   = $urandom_range(1900, 9999);
        d   = $urandom_range(27, 31);
        off = int'($urandom_range(0, 800)) - 400;
      end else begin
        y = $urandom_range(0, 16383);
        m = $urandom_range(0, 15);
        d = $urandom_range(0, 31);
      end
      send_date(y, m, d, off);
      if (i % 100 == 99) drain_results();
      else idle_gap();
    end

    // Wait for every result, then watch a while longer for a stray strobe.
    drain_results();
    repeat (64) @(negedge clk);

    $display("Sent %0d transactions; %0d results checked.", n_sent, n_checked);
    $display("Of those, %0d had an invalid start date and %0d moved out of range.",
             n_bad_date, n_range);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
